// ===== hw/rtl/tli_pkg.sv =====
package tli_pkg;

    localparam int XW = 16;
    localparam int YW = 16;
    localparam int STW = 3;
    localparam int CFGW = 7;
    localparam int FIDXW = 6;

    typedef enum logic [STW-1:0] {
        ST_INTERP = 3'd0,
        ST_EXACT  = 3'd1,
        ST_BELOW  = 3'd2,
        ST_ABOVE  = 3'd3,
        ST_FLAT   = 3'd4,
        ST_WRITE  = 3'd5
    } t_status;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // one queued transaction between front and back
    typedef struct packed {
        logic             opcode;
        logic [FIDXW-1:0] entry_index;
        logic [XW-1:0]    x_value;
        logic [YW-1:0]    y_value;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_WALK,
        S_RDSEG,
        S_SEGW,
        S_MUL,
        S_DIV,
        S_ROUND,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/tli_front.sv =====
module tli_front
    import tli_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_cmd       i_cmd,
    output logic       o_q_valid,
    input  logic       i_q_pop,
    output t_cmd       o_q_cmd
);

    // two-entry queue
    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

endmodule

// ===== hw/rtl/tli_back.sv =====
module tli_back
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  t_cmd                 i_cmd,
    input  logic [CFGW-1:0]      i_entries,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [YW-1:0] o_y_result,
    output logic [STW-1:0]       o_status,
    output logic [FIDXW-1:0]     o_segment_index
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = AW + 1;
    localparam int NW = 34;
    localparam int DW = 17;

    logic signed [XW-1:0] r_xmem [TABLE_DEPTH];
    logic signed [YW-1:0] r_ymem [TABLE_DEPTH];
    logic signed [XW-1:0] r_xrd;
    logic signed [YW-1:0] r_yrd;
    logic [AW-1:0]        rd_addr;

    t_state r_state, n_state;
    logic signed [XW-1:0] r_qx;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_n;
    logic [AW-1:0] r_seg, n_seg;
    logic          r_hi;
    logic signed [XW-1:0] r_a;
    logic signed [YW-1:0] r_fa;
    t_status r_st, n_st;
    logic [DW-1:0]       r_dx;
    logic [DW-1:0]       r_dy;
    logic [DW-1:0]       r_den;
    logic [NW:0]         r_num;
    logic                r_neg;
    logic [NW:0]         r_rem;
    logic [NW:0]         r_quo;
    logic [5:0]          r_bit;

    logic [CW-1:0] n_clamped;
    logic signed [DW:0] dx_w;
    logic signed [DW:0] dy_w;
    logic signed [DW:0] seg_w;
    logic [2*DW-1:0] prod;
    logic [NW+1:0] trial;
    logic signed [NW+2:0] rnd_sum;

    always_comb begin
        if (i_entries < CFGW'(2)) n_clamped = CW'(2);
        else if ({{(32-CFGW){1'b0}}, i_entries} > 32'(TABLE_DEPTH))
            n_clamped = CW'(TABLE_DEPTH);
        else n_clamped = CW'(i_entries);
    end

    // read address by state
    always_comb begin
        unique case (r_state)
            S_RDSEG: rd_addr = r_hi ? AW'(r_seg + 1'b1) : r_seg;
            default: rd_addr = r_i[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid && i_cmd.opcode == OP_WRITE
            && {{(32-FIDXW){1'b0}}, i_cmd.entry_index} < 32'(TABLE_DEPTH)) begin
            r_xmem[AW'(i_cmd.entry_index)] <= i_cmd.x_value;
            r_ymem[AW'(i_cmd.entry_index)] <= i_cmd.y_value;
        end
        r_xrd <= r_xmem[rd_addr];
        r_yrd <= r_ymem[rd_addr];
    end

    // r_a/r_fa hold the lower entry; r_xrd/r_yrd hold the upper entry in S_SEGW
    assign dx_w  = (DW+1)'(r_qx) - (DW+1)'(r_a);
    assign dy_w  = (DW+1)'(r_yrd) - (DW+1)'(r_fa);
    assign seg_w = (DW+1)'(r_xrd) - (DW+1)'(r_a);
    assign prod  = r_dx * r_dy;

    assign trial = {r_rem[NW:0], r_num[NW]} - {{(NW+1-DW){1'b0}}, r_den, 1'b0};
    assign rnd_sum = (r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo}))
                     + (NW+3)'(r_fa);

    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_seg = r_seg;
        n_st = r_st;
        o_q_pop = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_q_valid) begin
                o_q_pop = 1'b1;
                n_i = '0;
                n_state = (i_cmd.opcode == OP_WRITE) ? S_OUT : S_RD0;
            end
            S_RD0: n_state = S_WALK;
            S_WALK: begin
                if (r_i == '0 && r_qx < r_xrd) begin
                    n_seg = '0; n_st = ST_BELOW; n_state = S_RDSEG;
                end else if (r_xrd == r_qx) begin
                    n_seg = r_i[AW-1:0]; n_st = ST_EXACT; n_state = S_OUT;
                end else if (r_xrd > r_qx) begin
                    n_seg = (r_i == '0) ? '0 : AW'(r_i - 1'b1);
                    n_st = ST_INTERP; n_state = S_RDSEG;
                end else if (r_i + 1'b1 >= r_n) begin
                    n_seg = AW'(r_n - CW'(2)); n_st = ST_ABOVE; n_state = S_RDSEG;
                end else begin
                    n_i = r_i + 1'b1; n_state = S_RD0;
                end
            end
            S_RDSEG: n_state = r_hi ? S_SEGW : S_RDSEG;
            S_SEGW: begin
                n_state = S_MUL;
                if (seg_w == '0) n_st = ST_FLAT;
            end
            S_MUL: n_state = (r_st == ST_FLAT) ? S_OUT : S_DIV;
            S_DIV: n_state = (r_bit == '0) ? S_ROUND : S_DIV;
            S_ROUND: n_state = S_OUT;
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (n_state == S_OUT);
        end
        r_i <= n_i;
        r_seg <= n_seg;
        r_st <= n_st;
        unique case (r_state)
            S_IDLE: begin
                r_qx <= i_cmd.x_value;
                r_n <= n_clamped;
                r_hi <= 1'b0;
                if (i_cmd.opcode == OP_WRITE) begin
                    o_y_result <= '0;
                    o_status <= ST_WRITE;
                    o_segment_index <= '0;
                end
            end
            S_WALK: begin
                r_hi <= 1'b0;
                if (n_state == S_OUT) begin
                    o_y_result <= r_yrd;
                    o_status <= ST_EXACT;
                    o_segment_index <= FIDXW'(r_i);
                end
            end
            // lower entry address issued first, upper second
            S_RDSEG: begin
                r_hi <= 1'b1;
                if (r_hi) begin
                    r_a  <= r_xrd;
                    r_fa <= r_yrd;
                end
            end
            S_SEGW: begin
                r_dx  <= DW'(dx_w[DW] ? -dx_w : dx_w);
                r_dy  <= DW'(dy_w[DW] ? -dy_w : dy_w);
                r_den <= DW'(seg_w[DW] ? -seg_w : seg_w);
                r_neg <= dx_w[DW] ^ dy_w[DW] ^ seg_w[DW];
            end
            S_MUL: begin
                r_num <= {prod[NW-1:0], 1'b0} + {{(NW+1-DW){1'b0}}, r_den};
                r_rem <= '0;
                r_quo <= '0;
                r_bit <= 6'(NW);
                if (r_st == ST_FLAT) begin
                    o_y_result <= r_fa;
                    o_status <= ST_FLAT;
                    o_segment_index <= FIDXW'(r_seg);
                end
            end
            // restoring divide of 2*num + den by 2*den, rounds half away from zero
            S_DIV: begin
                if (!trial[NW+1]) begin
                    r_rem <= trial[NW:0];
                    r_quo <= {r_quo[NW-1:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[NW-1:0], r_num[NW]};
                    r_quo <= {r_quo[NW-1:0], 1'b0};
                end
                r_num <= {r_num[NW-1:0], 1'b0};
                r_bit <= r_bit - 1'b1;
            end
            S_ROUND: begin
                if (rnd_sum > (NW+3)'(32767)) o_y_result <= 16'sh7fff;
                else if (rnd_sum < -(NW+3)'(32768)) o_y_result <= 16'sh8000;
                else o_y_result <= rnd_sum[YW-1:0];
                o_status <= r_st;
                o_segment_index <= FIDXW'(r_seg);
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/table_linear_interpolator.sv =====
// channel | direction | handshake     | payload
// query   | in        | valid / stall | opcode, entry_index, x_value, y_value
// result  | out       | valid / stall | y_result, status, segment_index
// config  | in        | valid / ready | entries_in_use
// a write is a queue pop then a result; a query is a pop, then a read and a compare per breakpoint
// exact hit: result next; else segment read, multiply, restoring divide, round, result
// a zero-width segment goes out after the multiply
// two-entry queue stalls the input only when full; a stalled result holds the back end
// reset is synchronous and clears control state and sets entries_in_use to 2
module table_linear_interpolator
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_opcode,
    input  logic [FIDXW-1:0]     i_entry_index,
    input  logic signed [XW-1:0] i_x_value,
    input  logic signed [YW-1:0] i_y_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [YW-1:0] o_y_result,
    output logic [STW-1:0]       o_status,
    output logic [FIDXW-1:0]     o_segment_index,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFGW-1:0]      i_cfg_data
);

    logic [CFGW-1:0] r_entries;
    t_cmd cmd_in, q_cmd;
    logic q_valid, q_pop;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_entries <= CFGW'(2);
        else if (i_cfg_valid) r_entries <= i_cfg_data;
    end

    assign cmd_in = '{opcode: i_opcode, entry_index: i_entry_index,
                      x_value: i_x_value, y_value: i_y_value};

    tli_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_cmd(cmd_in),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_cmd(q_cmd)
    );

    tli_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_cmd(q_cmd),
        .i_entries(r_entries), .o_valid, .i_stall, .o_y_result, .o_status,
        .o_segment_index
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb
    import tli_pkg::*;
();

    localparam int DEPTH = 64;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic signed [YW-1:0] y_result;
        t_status              status;
        logic [FIDXW-1:0]     segment_index;
    } t_interp_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_opcode = OP_WRITE;
    logic [FIDXW-1:0]     i_entry_index = '0;
    logic signed [XW-1:0] i_x_value = '0;
    logic signed [YW-1:0] i_y_value = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [YW-1:0] o_y_result;
    logic [STW-1:0]       o_status;
    logic [FIDXW-1:0]     o_segment_index;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFGW-1:0]      i_cfg_data = '0;

    // predictor state
    logic signed [XW-1:0] bp_x [DEPTH];
    logic signed [YW-1:0] bp_y [DEPTH];
    int                   bp_count = 2;

    t_interp_out pending_results[$];
    int          error_count = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;

    table_linear_interpolator #(.TABLE_DEPTH(DEPTH)) u_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic int segment_value(int s, int x, output bit flat);
        int     a, c, fa, fc;
        longint num, den, mn, md, q, res;
        bit     neg;
        a = bp_x[s];
        c = bp_x[s+1];
        fa = bp_y[s];
        fc = bp_y[s+1];
        if (c == a) begin
            flat = 1'b1;
            return fa;
        end
        flat = 1'b0;
        num = longint'(x - a) * longint'(fc - fa);
        den = c - a;
        neg = (num < 0) != (den < 0);
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        q = (mn * 2 + md) / (md * 2);
        res = fa + (neg ? -q : q);
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return int'(res);
    endfunction

    function automatic t_interp_out interpolate(t_cmd c);
        t_interp_out r;
        int          n, x, seg, res;
        bit          flat, found;
        r.y_result = '0;
        r.status = ST_WRITE;
        r.segment_index = '0;
        if (c.opcode == OP_WRITE) begin
            bp_x[c.entry_index] = c.x_value;
            bp_y[c.entry_index] = c.y_value;
            return r;
        end
        n = bp_count < 2 ? 2 : (bp_count > DEPTH ? DEPTH : bp_count);
        x = $signed(c.x_value);
        flat = 1'b0;
        found = 1'b0;
        seg = 0;
        res = 0;
        if (x < bp_x[0]) begin
            r.status = ST_BELOW;
            res = segment_value(0, x, flat);
        end else begin
            r.status = ST_ABOVE;
            for (int i = 0; i < n && !found; i++) begin
                if (bp_x[i] == x) begin
                    seg = i;
                    r.status = ST_EXACT;
                    res = bp_y[i];
                    found = 1'b1;
                end else if (bp_x[i] > x) begin
                    seg = (i == 0) ? 0 : i - 1;
                    r.status = ST_INTERP;
                    res = segment_value(seg, x, flat);
                    found = 1'b1;
                end
            end
            if (!found) begin
                seg = n - 2;
                res = segment_value(seg, x, flat);
            end
        end
        if (flat && r.status != ST_EXACT) r.status = ST_FLAT;
        r.y_result = res[YW-1:0];
        r.segment_index = seg[FIDXW-1:0];
        return r;
    endfunction

    // called just after a rising edge; leaves i_valid high, bar random idle gaps
    task automatic send_item(logic op, int idx, int x, int y);
        t_cmd        c;
        t_interp_out exp_item;
        c.opcode = op;
        c.entry_index = idx[FIDXW-1:0];
        c.x_value = x[XW-1:0];
        c.y_value = y[YW-1:0];
        i_valid <= 1'b1;
        i_opcode <= c.opcode;
        i_entry_index <= c.entry_index;
        i_x_value <= c.x_value;
        i_y_value <= c.y_value;
        do @(posedge i_clk); while (o_stall);
        exp_item = interpolate(c);
        pending_results = {pending_results, exp_item};
        items_sent++;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic write_entries_in_use(int value);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value[CFGW-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        bp_count = value & 7'h7f;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random ascending table, duplicates now and then; unsorted once in a while
    task automatic load_table(int n);
        int x;
        bit unsorted;
        unsorted = ($urandom_range(0, 7) == 0);
        x = $urandom_range(0, 40000) - 32768;
        for (int i = 0; i < n; i++) begin
            if (unsorted) x = $urandom_range(0, 65535) - 32768;
            send_item(OP_WRITE, i, x, $urandom_range(0, 65535) - 32768);
            if (!unsorted) begin
                if ($urandom_range(0, 9) == 0) x = x;
                else if ($urandom_range(0, 3) == 0) x = x + $urandom_range(1, 8);
                else x = x + $urandom_range(1, 2000);
                if (x > 32767) x = 32767;
            end
        end
    endtask

    task automatic test_fill_all_slots();
        for (int i = 0; i < DEPTH; i++)
            send_item(OP_WRITE, i, i * 16, i * 64);
    endtask

    task automatic test_directed();
        write_entries_in_use(4);
        send_item(OP_WRITE, 0, -100, -32768);
        send_item(OP_WRITE, 1, 0, 32767);
        send_item(OP_WRITE, 2, 256, 1000);
        send_item(OP_WRITE, 3, 256, 5);
        send_item(OP_QUERY, 63, -32768, 32767);
        send_item(OP_QUERY, 0, -100, -32768);
        send_item(OP_QUERY, 0, -50, 0);
        send_item(OP_QUERY, 0, 0, 0);
        send_item(OP_QUERY, 0, 100, 0);
        send_item(OP_QUERY, 0, 256, 0);
        send_item(OP_QUERY, 0, 32767, 0);
        // above range on a sloped last segment
        send_item(OP_WRITE, 3, 300, -32768);
        send_item(OP_QUERY, 0, 32767, 0);
        // flat first segment below range
        send_item(OP_WRITE, 1, -100, 7);
        send_item(OP_QUERY, 0, -32768, 0);
        send_item(OP_QUERY, 0, 32767, -1);
    endtask

    task automatic test_random_tables();
        int cfg, n, span_lo, span_hi, x;
        while (items_sent < 1650) begin
            if (items_sent > 1450) quiet = 1'b1;
            case ($urandom_range(0, 11))
                0: cfg = 0;
                1: cfg = 1;
                2: cfg = 64;
                3: cfg = 127;
                4: cfg = $urandom_range(65, 126);
                5: cfg = $urandom_range(9, 63);
                default: cfg = $urandom_range(2, 8);
            endcase
            write_entries_in_use(cfg);
            n = cfg < 2 ? 2 : (cfg > DEPTH ? DEPTH : cfg);
            load_table(n);
            span_lo = bp_x[0] - 500;
            span_hi = bp_x[n-1] + 500;
            if (span_hi < span_lo) span_hi = span_lo + 1000;
            repeat ($urandom_range(20, 40)) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_item(OP_WRITE, $urandom_range(0, 63),
                              $urandom_range(0, 65535) - 32768,
                              $urandom_range(0, 65535) - 32768);
                end else begin
                    case ($urandom_range(0, 5))
                        0: x = $urandom_range(0, 65535) - 32768;
                        1: x = bp_x[$urandom_range(0, n - 1)];
                        default: x = span_lo + $urandom_range(0, span_hi - span_lo);
                    endcase
                    if (x > 32767) x = 32767;
                    if (x < -32768) x = -32768;
                    send_item(OP_QUERY, $urandom_range(0, 63), x,
                              $urandom_range(0, 65535) - 32768);
                end
            end
        end
        i_valid <= 1'b0;
    endtask

    // result side stall bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (quiet) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_stall <= ~i_stall;
            stall_left <= $urandom_range(1, 18);
        end
    end

    always @(posedge i_clk) begin
        t_interp_out exp_r;
        if (o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_y_result !== exp_r.y_result) begin
                    $error("y_result expected %0d actual %0d", exp_r.y_result, o_y_result);
                    error_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_status);
                    error_count++;
                end
                if (o_segment_index !== exp_r.segment_index) begin
                    $error("segment_index expected %0d actual %0d",
                           exp_r.segment_index, o_segment_index);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** table_linear_interpolator: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_all_slots();
        test_directed();
        test_random_tables();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0)
            $display("** table_linear_interpolator: PASSED **");
        else
            $display("** table_linear_interpolator: FAILED **");
        $finish;
    end

endmodule
